### hdl/bal_pkg.sv
// ----------------------------------------------------------------------------
// bal_pkg: shared types and codes for the bounded array list
// Capacity, field widths, command and status codes, item and memory structs.
// ----------------------------------------------------------------------------
`default_nettype none

package bal_pkg;

  localparam int unsigned CAPACITY = 8;

  // store index and element count widths follow the capacity
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // fixed field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned POS_W   = 3;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned FOUND_W = 3;
  localparam int unsigned ECNT_W  = 4;

  // common width for comparing a position against the count
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_BADIDX   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] removed_value;
    logic [FOUND_W-1:0]      found_position;
    logic [ECNT_W-1:0]       element_count;
  } out_item_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

### hdl/bounded_array_list.sv
// ----------------------------------------------------------------------------
// bounded_array_list: fixed-capacity ordered list of signed words
// Append, remove by position with shift-down, and first-match search.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+------------------------------
//  in      | in_valid_i / in_ready_o  | in_i  (command, value, position)
//  out     | out_valid_o / out_ready_i| out_o (status, removed_value,
//          |                        |        found_position, element_count)
//
//  Append and every rejected command go from accept straight to the result.
//  Remove at position p reads the word at p, then moves each word above it down:
//  one store read per moved word and one write, through the single store port pair.
//  Search reads from index 0 up to the first hit or the end of the list: one
//  compare per cycle on the registered read data.
//  Reset empties the list at once; no clearing pass. A stalled result sits in
//  the output register while the next item is taken and worked on.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_array_list (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bal_pkg::in_item_t  in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bal_pkg::out_item_t out_o
);
  import bal_pkg::*;

  mem_req_t         mem_req;
  logic [VAL_W-1:0] mem_rdata;
  logic             res_valid;
  logic             res_ready;
  out_item_t        res;
  logic             out_vld_q;
  out_item_t        out_q;

  bal_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  bal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // take a new result when the output slot is empty or draining
  assign res_ready = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("sequencer ready right after taking an item");

  a_fail_clears_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status != ST_OK |->
      out_o.removed_value == '0 && out_o.found_position == '0)
    else $error("failed command carries data");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status == ST_FULL |->
      out_o.element_count == ECNT_W'(CAPACITY))
    else $error("full status with list not at capacity");

endmodule

`default_nettype wire

### hdl/bal_mem.sv
// ----------------------------------------------------------------------------
// bal_mem: element store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bal_mem (
  input  logic                              clk_i,
  input  bal_pkg::mem_req_t                 req_i,
  output logic [bal_pkg::VAL_W-1:0]         rdata_o
);
  import bal_pkg::*;

  logic [VAL_W-1:0] mem_q [CAPACITY];
  logic [VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hdl/bal_ctrl.sv
// ----------------------------------------------------------------------------
// bal_ctrl: command sequencer
// Steps one command at a time through the store using an index increment
// and count compare shared by remove and search, and a value compare.
// ----------------------------------------------------------------------------
`default_nettype none

module bal_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  bal_pkg::in_item_t         in_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output bal_pkg::out_item_t        res_o,
  output bal_pkg::mem_req_t         mem_req_o,
  input  logic [bal_pkg::VAL_W-1:0] mem_rdata_i
);
  import bal_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RM_TAKE = 3'd1;
  localparam logic [2:0] S_SH_WR   = 3'd2;
  localparam logic [2:0] S_SH_CHK  = 3'd3;
  localparam logic [2:0] S_SR_CMP  = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [VAL_W-1:0]   val_q, val_d;
  logic [STAT_W-1:0]  status_q, status_d;
  logic [VAL_W-1:0]   removed_q, removed_d;
  logic [FOUND_W-1:0] found_q, found_d;

  logic [CNT_W-1:0]   nxt;
  logic               more;
  logic               hit;
  logic               full;
  logic               empty;
  logic               pos_ok;
  logic               accept;

  // next index and bound check against the count, shared by remove and search; word compare for search
  assign nxt    = CNT_W'(idx_q) + CNT_W'(1);
  assign more   = nxt < cnt_q;
  assign hit    = mem_rdata_i == val_q;
  assign full   = cnt_q == CNT_W'(CAPACITY);
  assign empty  = cnt_q == '0;
  assign pos_ok = CMP_W'(in_i.position) < CMP_W'(cnt_q);

  assign in_ready_o = state_q == S_IDLE;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    val_d     = val_q;
    status_d  = status_q;
    removed_d = removed_q;
    found_d   = found_q;
    mem_req_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          val_d     = in_i.value;
          status_d  = ST_OK;
          removed_d = '0;
          found_d   = '0;
          state_d   = S_DONE;
          case (in_i.command)
            CMD_APPEND: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = IDX_W'(cnt_q);
                mem_req_o.wdata = in_i.value;
                cnt_d           = cnt_q + CNT_W'(1);
              end
            end
            CMD_REMOVE: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else if (!pos_ok) begin
                status_d = ST_BADIDX;
              end else begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = IDX_W'(in_i.position);
                idx_d           = IDX_W'(in_i.position);
                state_d         = S_RM_TAKE;
              end
            end
            CMD_SEARCH: begin
              if (empty) begin
                status_d = ST_NOTFOUND;
              end else begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = '0;
                idx_d           = '0;
                state_d         = S_SR_CMP;
              end
            end
            default: ;
          endcase
        end
      end

      S_RM_TAKE, S_SH_CHK: begin
        if (state_q == S_RM_TAKE) begin
          removed_d = mem_rdata_i;
        end
        // fetch the next word to move down, or close the gap
        if (more) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = IDX_W'(nxt);
          state_d         = S_SH_WR;
        end else begin
          cnt_d   = cnt_q - CNT_W'(1);
          state_d = S_DONE;
        end
      end

      S_SH_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = idx_q;
        mem_req_o.wdata = mem_rdata_i;
        idx_d           = IDX_W'(nxt);
        state_d         = S_SH_CHK;
      end

      S_SR_CMP: begin
        if (hit) begin
          found_d = FOUND_W'(idx_q);
          state_d = S_DONE;
        end else if (more) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = IDX_W'(nxt);
          idx_d           = IDX_W'(nxt);
        end else begin
          status_d = ST_NOTFOUND;
          state_d  = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    val_q     <= val_d;
    status_q  <= status_d;
    removed_q <= removed_d;
    found_q   <= found_d;
  end

  assign res_valid_o          = state_q == S_DONE;
  assign res_o.status         = status_q;
  assign res_o.removed_value  = removed_q;
  assign res_o.found_position = found_q;
  assign res_o.element_count  = ECNT_W'(cnt_q);

endmodule

`default_nettype wire

### tb/sv/bounded_array_list_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_array_list_tb: self-checking bench for the bounded array list
// Drives append, remove, search and unused commands through the valid/ready input
// channel, predicts each result from a shadow copy of the list and checks
// every returned item field by field. Both sides idle at random, and the
// output side holds off once long enough to back the block up.
// ----------------------------------------------------------------------------

module bounded_array_list_tb;
  import bal_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned N_RANDOM    = 800;
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned HOLD_AT     = 300;
  localparam int unsigned DRAIN_AT    = 400;
  localparam int unsigned TAIL_CYCLES = 40;

  typedef struct packed {
    logic     drain;
    in_item_t item;
  } pending_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item = '0;
  logic      out_valid_o;
  logic      out_ready = 1'b0;
  out_item_t out_o;

  bounded_array_list dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_i        (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_o       (out_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  pending_t  pending_items[$];
  out_item_t list_results[$];
  int        n_accepted = 0;
  int        n_returned = 0;
  int        errors = 0;

  // shadow of the list as the block should hold it
  logic signed [VAL_W-1:0] list_words [CAPACITY];
  int unsigned             list_len = 0;

  function automatic out_item_t apply_command(in_item_t it);
    out_item_t   r;
    int unsigned k;
    bit          hit;
    r = '0;
    r.status = ST_OK;
    hit = 1'b0;
    case (it.command)
      CMD_APPEND: begin
        if (list_len < CAPACITY) begin
          list_words[list_len] = it.value;
          list_len++;
        end else begin
          r.status = ST_FULL;
        end
      end
      CMD_REMOVE: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else if (it.position >= list_len) begin
          r.status = ST_BADIDX;
        end else begin
          r.removed_value = list_words[it.position];
          for (k = it.position; k + 1 < list_len; k++) list_words[k] = list_words[k + 1];
          list_len--;
        end
      end
      CMD_SEARCH: begin
        for (k = 0; k < list_len; k++) begin
          if (!hit && list_words[k] == it.value) begin
            r.found_position = FOUND_W'(k);
            hit = 1'b1;
          end
        end
        if (!hit) r.status = ST_NOTFOUND;
      end
      default: ;
    endcase
    r.element_count = ECNT_W'(list_len);
    return r;
  endfunction

  // driver
  logic send_fire;
  int   send_gap = 0;
  int   send_stretch = 0;
  bit   send_quiet = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      in_item    <= '0;
      n_accepted <= 0;
    end else begin
      send_fire = in_valid && in_ready_o;
      if (send_fire) begin
        list_results.push_back(apply_command(in_item));
        n_accepted <= n_accepted + 1;
        if (send_stretch == 0) begin
          send_stretch = $urandom_range(10, 60);
          send_quiet = ($urandom_range(0, 2) == 0);
        end
        send_stretch--;
        send_gap = send_quiet ? 0 : $urandom_range(0, 17);
      end
      if (send_fire || !in_valid) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0 &&
                     (!pending_items[0].drain || (!send_fire && n_returned == n_accepted))) begin
          in_item  <= pending_items.pop_front().item;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  out_item_t want;
  int        recv_wait = 0;
  int        recv_stretch = 0;
  bit        recv_quiet = 1'b0;
  bit        long_hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      n_returned <= 0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (list_results.size() == 0) begin
          $error("result item with nothing pending: status %0d count %0d",
                 out_o.status, out_o.element_count);
          errors++;
        end else begin
          want = list_results.pop_front();
          if (out_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_o.status);
            errors++;
          end
          if (out_o.removed_value !== want.removed_value) begin
            $error("removed_value: expected %0d, got %0d",
                   want.removed_value, out_o.removed_value);
            errors++;
          end
          if (out_o.found_position !== want.found_position) begin
            $error("found_position: expected %0d, got %0d",
                   want.found_position, out_o.found_position);
            errors++;
          end
          if (out_o.element_count !== want.element_count) begin
            $error("element_count: expected %0d, got %0d",
                   want.element_count, out_o.element_count);
            errors++;
          end
        end
        n_returned <= n_returned + 1;
        if (!long_hold_done && n_returned == HOLD_AT) begin
          // hold off long enough for the input side to back up
          recv_wait = HOLD_CYCLES;
          long_hold_done = 1'b1;
        end else begin
          if (recv_stretch == 0) begin
            recv_stretch = $urandom_range(10, 60);
            recv_quiet = ($urandom_range(0, 2) == 0);
          end
          recv_stretch--;
          recv_wait = recv_quiet ? 0 : $urandom_range(0, 17);
        end
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // stimulus
  int unsigned             gen_len = 0;
  logic signed [VAL_W-1:0] value_pool[$];

  task automatic add_item(logic [CMD_W-1:0] cmd, logic signed [VAL_W-1:0] val,
                          logic [POS_W-1:0] pos, bit drain);
    pending_t p;
    p.drain = drain;
    p.item.command = cmd;
    p.item.value = val;
    p.item.position = pos;
    pending_items.push_back(p);
    // track length, to aim removes at live positions, and a pool of recent appended values
    if (cmd == CMD_APPEND && gen_len < CAPACITY) begin
      gen_len++;
      value_pool.push_back(val);
      if (value_pool.size() > 16) void'(value_pool.pop_front());
    end else if (cmd == CMD_REMOVE && pos < gen_len) begin
      gen_len--;
    end
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value(int unsigned pool_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < pool_pct && value_pool.size() != 0)
      return value_pool[$urandom_range(0, value_pool.size() - 1)];
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sh0;
      3: return -32'sh1;
      default: return $urandom;
    endcase
  endfunction

  int unsigned             phase_left = 0;
  int unsigned             bias = 0;
  int unsigned             r;
  logic [POS_W-1:0]        pos;
  logic signed [VAL_W-1:0] val;

  initial begin
    // empty list corner cases
    add_item(CMD_SEARCH, 32'sh0, 3'd0, 1'b0);
    add_item(CMD_REMOVE, 32'sh0, 3'd0, 1'b0);
    add_item(CMD_UNUSED, -32'sh1, 3'd7, 1'b0);
    // fill up, with a duplicate for the first-match check
    add_item(CMD_APPEND, 32'sh7FFF_FFFF, 3'd7, 1'b0);
    add_item(CMD_APPEND, 32'sh8000_0000, 3'd0, 1'b0);
    add_item(CMD_APPEND, 32'sh0, 3'd0, 1'b0);
    add_item(CMD_APPEND, -32'sh1, 3'd5, 1'b0);
    add_item(CMD_APPEND, 32'sh5, 3'd2, 1'b0);
    add_item(CMD_APPEND, 32'sh5, 3'd0, 1'b0);
    add_item(CMD_APPEND, 32'sh5555_5555, 3'd0, 1'b0);
    add_item(CMD_APPEND, 32'shAAAA_AAAA, 3'd0, 1'b0);
    add_item(CMD_APPEND, 32'sh1, 3'd0, 1'b0);
    add_item(CMD_SEARCH, -32'sh1, 3'd0, 1'b0);
    add_item(CMD_SEARCH, 32'sh5, 3'd7, 1'b0);
    add_item(CMD_SEARCH, 32'shAAAA_AAAA, 3'd0, 1'b0);
    add_item(CMD_SEARCH, 32'sh7B, 3'd0, 1'b0);
    add_item(CMD_SEARCH, 32'sh7FFF_FFFF, 3'd0, 1'b0);
    add_item(CMD_REMOVE, 32'sh0, 3'd0, 1'b0);
    add_item(CMD_REMOVE, 32'sh0, 3'd7, 1'b0);
    add_item(CMD_REMOVE, 32'sh0, 3'd6, 1'b0);
    add_item(CMD_REMOVE, 32'sh0, 3'd2, 1'b0);
    add_item(CMD_UNUSED, 32'sh8000_0000, 3'd0, 1'b0);
    add_item(CMD_SEARCH, 32'sh5, 3'd0, 1'b0);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(10, 40);
        bias = $urandom_range(0, 2);
      end
      phase_left--;
      r = $urandom_range(0, 99);
      pos = POS_W'($urandom_range(0, 7));
      if (r < 3) begin
        add_item(CMD_UNUSED, $urandom, pos, i == DRAIN_AT);
      end else if (r < (bias == 0 ? 70 : bias == 1 ? 20 : 40)) begin
        add_item(CMD_APPEND, pick_value(30), pos, i == DRAIN_AT);
      end else if (r < (bias == 0 ? 85 : bias == 1 ? 80 : 70)) begin
        if (gen_len != 0 && $urandom_range(0, 99) < 85) begin
          pos = POS_W'($urandom_range(0, gen_len - 1));
        end
        add_item(CMD_REMOVE, $urandom, pos, i == DRAIN_AT);
      end else begin
        val = pick_value(65);
        add_item(CMD_SEARCH, val, pos, i == DRAIN_AT);
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sample on the falling edge so the driver and monitor have settled
    while (pending_items.size() != 0 || in_valid || n_returned != n_accepted)
      @(negedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (list_results.size() != 0) begin
      $error("%0d result items never arrived", list_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
